[rtl/simp_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the simp-256 permutation core
// no dependencies; imported by every module of the block
package simp_pkg;

	localparam int WORD_W          = 64;
	localparam int NUM_WORDS       = 4;
	localparam int ROUNDS_PER_STEP = 34;
	localparam int DBL_ROUNDS      = ROUNDS_PER_STEP / 2;
	localparam int RND_W           = (DBL_ROUNDS > 1) ? $clog2(DBL_ROUNDS) : 1;
	localparam int STEP_W          = 8;
	localparam int RC_W            = 62;

	localparam logic [63:0]       RC_INIT_FULL = 64'h3369_F885_192C_0EF5;
	localparam logic [RC_W-1:0]   RC_INIT      = RC_INIT_FULL[RC_W-1:0];
	localparam logic [WORD_W-1:0] MIX_CONST    = 64'hFFFF_FFFF_FFFF_FFFC;
	localparam logic [RND_W-1:0]  RND_LAST     = RND_W'(DBL_ROUNDS - 1);

	typedef logic [WORD_W-1:0] word_t;
	// entry 0 is x0, which also sits in the lowest bits of tdata
	typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic load;
		logic advance;
		logic swap;
		logic flush;
	} seq_ctrl_t;

endpackage

[rtl/simp_256_permutation_core.sv]
`timescale 1ns / 1ps
// top level of the simp-256 permutation core
// depends on simp_pkg, simp_seq and simp_round
//
// usage:
//  s_* stream carries one 256-bit state per request, m_* returns the permuted
//  state; tdata packs words x0..x3 from the lowest bits up.
//  cfg_* writes step_count (steps per call, 0 runs as 1); write it while idle.
//  a request is taken only in the idle state, then one shared double-round
//  unit runs once per cycle, 17 double rounds per step, swapping halves
//  between steps. the next request is taken the cycle after the result is
//  moved into the output register, so a new request is not taken until
//  the previous result has left the state registers.
//  when the receiver stalls, the result waits in the output register and the
//  next request is still taken and computed; it then waits in the state
//  registers until the output register frees up.
//  reset clears the sequencer and output valid and sets step_count to 2.
module simp_256_permutation_core import simp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [255:0]      s_tdata,  // word0_in, word1_in, word2_in, word3_in
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [255:0]      m_tdata,  // word0_out, word1_out, word2_out, word3_out
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [STEP_W-1:0] cfg_data  // step_count
);

	seq_ctrl_t         ctrl;
	logic [STEP_W-1:0] step_count_q;
	state_t            x_q;
	state_t            x_rnd;
	logic [RC_W-1:0]   rc_q;
	state_t            out_q;
	logic              out_valid_q;
	logic              out_free;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	simp_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.out_free   (out_free),
		.step_count (step_count_q),
		.in_ready   (s_tready),
		.ctrl       (ctrl)
	);

	simp_round u_round (
		.x       (x_q),
		.rc_bits (rc_q[1:0]),
		.y       (x_rnd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= STEP_W'(2);
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				step_count_q <= cfg_data;
			end
			if (ctrl.flush) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q  <= s_tdata;
			rc_q <= RC_INIT;
		end else if (ctrl.advance) begin
			// round constant moves two bits per double round
			rc_q <= {rc_q[1:0], rc_q[RC_W-1:2]};
			if (ctrl.swap) begin
				x_q[0] <= x_rnd[2];
				x_q[1] <= x_rnd[3];
				x_q[2] <= x_rnd[0];
				x_q[3] <= x_rnd[1];
			end else begin
				x_q <= x_rnd;
			end
		end
		if (ctrl.flush) begin
			out_q <= x_q;
		end
	end

endmodule

[rtl/simp_round.sv]
`timescale 1ns / 1ps
// one simon-style double round over the four state words
// depends on simp_pkg
module simp_round import simp_pkg::*; (
	input  state_t     x,
	input  logic [1:0] rc_bits,
	output state_t     y
);

	function automatic word_t mix_f(input word_t v);
		mix_f = ({v[WORD_W-2:0], v[WORD_W-1]} & {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]})
			^ {v[WORD_W-3:0], v[WORD_W-1:WORD_W-2]};
	endfunction

	function automatic word_t mix_g(input word_t v);
		mix_g = {v[2:0], v[WORD_W-1:3]} ^ {v[3:0], v[WORD_W-1:4]} ^ MIX_CONST;
	endfunction

	word_t x3_n;
	word_t x1_n;
	word_t x2_n;
	word_t x0_n;

	always_comb begin
		x3_n = x[3] ^ mix_f(x[2]) ^ x[1];
		x1_n = x[1] ^ mix_g(x[0]) ^ {{(WORD_W-1){1'b0}}, rc_bits[0]};
		x2_n = x[2] ^ mix_f(x3_n) ^ x[0];
		x0_n = x[0] ^ mix_g(x1_n) ^ {{(WORD_W-1){1'b0}}, rc_bits[1]};
		y[0] = x0_n;
		y[1] = x1_n;
		y[2] = x2_n;
		y[3] = x3_n;
	end

endmodule

[rtl/simp_seq.sv]
`timescale 1ns / 1ps
// sequencer: counts double rounds and steps, drives the datapath controls
// depends on simp_pkg
module simp_seq import simp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_free,
	input  logic [STEP_W-1:0] step_count,
	output logic              in_ready,
	output seq_ctrl_t         ctrl
);

	seq_state_t        state_q;
	seq_state_t        state_d;
	logic [RND_W-1:0]  round_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] last_step;
	logic              round_end;

	// a step count of zero runs one step
	assign last_step = (step_count == '0) ? '0 : step_count - STEP_W'(1);
	assign round_end = (round_q == RND_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.load) begin
				round_q <= '0;
				step_q  <= '0;
			end else if (ctrl.advance) begin
				if (round_end) begin
					round_q <= '0;
					step_q  <= step_q + STEP_W'(1);
				end else begin
					round_q <= round_q + RND_W'(1);
				end
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ctrl.load = in_valid;
				if (in_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				ctrl.advance = 1'b1;
				if (round_end) begin
					if (step_q == last_step) begin
						state_d = ST_FLUSH;
					end else begin
						ctrl.swap = 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				ctrl.flush = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/simp_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the simp-256 permutation core, bound to the top level
// depends on simp_pkg
module simp_checker import simp_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [255:0] m_tdata
);

	// a stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// after taking a request the core is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while a permutation is running");

	// a new result only shows up from the busy phase
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while idle");

	// no result can appear right after a request
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

endmodule

bind simp_256_permutation_core simp_checker u_simp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[test/tb_simp_256_permutation_core.sv]
`timescale 1ns / 1ps
// self-checking testbench for simp_256_permutation_core, stream in/out plus cfg write
// depends on simp_pkg and the core rtl; predicts every permuted state in a scoreboard class
module tb_simp_256_permutation_core;
	import simp_pkg::*;

	// expected permuted states, computed at request acceptance
	class perm_checker;
		logic [STEP_W-1:0] steps;
		state_t expected_states[$];
		int errors;

		function new();
			steps = 8'd2;
			errors = 0;
		endfunction

		function word_t rotl(word_t v, int n);
			return (v << n) | (v >> (WORD_W - n));
		endfunction

		function word_t mix_f(word_t v);
			return (rotl(v, 1) & rotl(v, 8)) ^ rotl(v, 2);
		endfunction

		function word_t mix_g(word_t v);
			return rotl(v, WORD_W - 3) ^ rotl(v, WORD_W - 4) ^ MIX_CONST;
		endfunction

		function state_t simp_permute(state_t st);
			word_t x0, x1, x2, x3, t;
			logic [RC_W-1:0] z;
			logic b;
			int n_steps;
			x0 = st[0];
			x1 = st[1];
			x2 = st[2];
			x3 = st[3];
			z = RC_INIT;
			n_steps = (steps == 0) ? 1 : int'(steps);
			for (int s = 0; s < n_steps; s++) begin
				if (s != 0) begin
					t = x0; x0 = x2; x2 = t;
					t = x1; x1 = x3; x3 = t;
				end
				for (int r = 0; r < DBL_ROUNDS; r++) begin
					x3 ^= mix_f(x2) ^ x1;
					b = z[0];
					z = {b, z[RC_W-1:1]};
					x1 ^= mix_g(x0) ^ word_t'(b);
					x2 ^= mix_f(x3) ^ x0;
					b = z[0];
					z = {b, z[RC_W-1:1]};
					x0 ^= mix_g(x1) ^ word_t'(b);
				end
			end
			return {x3, x2, x1, x0};
		endfunction

		function void note_request(state_t st);
			expected_states.push_back(simp_permute(st));
		endfunction

		function void check_result(state_t got);
			state_t exp_st;
			if (expected_states.size() == 0) begin
				$error("unexpected result %h", got);
				errors++;
				return;
			end
			exp_st = expected_states.pop_front();
			for (int i = 0; i < NUM_WORDS; i++) begin
				if (got[i] !== exp_st[i]) begin
					$error("word%0d_out: expected %h, actual %h", i, exp_st[i], got[i]);
					errors++;
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [255:0]      s_tdata = '0;  // word0_in, word1_in, word2_in, word3_in
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [255:0]      m_tdata;       // word0_out, word1_out, word2_out, word3_out
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [STEP_W-1:0] cfg_data = '0;  // step_count

	perm_checker chk = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_ask = 0;

	simp_256_permutation_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// result side: check every accepted result, random stalls, long hold on request
	initial begin : result_drain
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				chk.check_result(m_tdata);
			if (hold_left == 0 && hold_ask != 0) begin
				hold_left = hold_ask;
				hold_ask = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	function automatic word_t rand_word();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_state(input state_t st);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= st;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		chk.note_request(st);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (chk.expected_states.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_step_count(input logic [STEP_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		chk.steps = v;
	endtask

	initial begin : stimulus
		int phase_send[3];
		int phase_recv[3];
		phase_send = '{28, 74, 0};
		phase_recv = '{74, 28, 0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset step count, corner patterns
		send_idle_pct = 28;
		recv_idle_pct = 74;
		send_state('0);
		send_state('1);
		send_state({4{64'hAAAA_AAAA_AAAA_AAAA}});
		send_state({4{64'h5555_5555_5555_5555}});
		send_state({64'h8000_0000_0000_0000, 64'h0, 64'h0, 64'h1});
		send_state({64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF});
		wait_drained();

		// zero step count runs one step
		write_step_count(8'd0);
		send_state('0);
		send_state({rand_word(), rand_word(), rand_word(), rand_word()});
		wait_drained();

		// largest step count
		write_step_count(8'd255);
		send_state('1);
		send_state({rand_word(), rand_word(), rand_word(), rand_word()});
		wait_drained();

		// long receiver hold so the core backs up and stalls its input
		write_step_count(8'd1);
		send_idle_pct = 0;
		hold_ask = 300;
		repeat (8)
			send_state({rand_word(), rand_word(), rand_word(), rand_word()});
		wait_drained();

		for (int p = 0; p < 3; p++) begin
			send_idle_pct = phase_send[p];
			recv_idle_pct = phase_recv[p];
			for (int blk = 0; blk < 10; blk++) begin
				write_step_count(8'($urandom_range(0, 6)));
				repeat (61)
					send_state({rand_word(), rand_word(), rand_word(), rand_word()});
				wait_drained();
			end
		end

		// catch any stray result after the last one
		repeat (300) @(posedge clk);
		if (chk.errors == 0 && chk.expected_states.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
